### rtl/core/nnt_pkg.sv
// Shared constants, types and the microcode program of the nearest-neighbor tour block.
package nnt_pkg;

    localparam int NODES      = 16;
    localparam int DIST_BITS  = 16;
    localparam int NODE_BITS  = $clog2(NODES);
    localparam int IDX_BITS   = NODE_BITS + 1;
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int DEPTH      = NODES * NODES;
    localparam int SPOT_W     = 4;
    localparam int REQ_W      = 2;
    localparam int IN_DIST_W  = 16;
    localparam int PC_BITS    = 3;
    localparam longint unsigned DIST_MAX = (64'd1 << DIST_BITS) - 64'd1;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MARK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    localparam logic [PC_BITS-1:0] PC_IDLE   = 3'd0;
    localparam logic [PC_BITS-1:0] PC_FIRST  = 3'd1;
    localparam logic [PC_BITS-1:0] PC_TEST   = 3'd2;
    localparam logic [PC_BITS-1:0] PC_SCAN   = 3'd3;
    localparam logic [PC_BITS-1:0] PC_MOVE   = 3'd4;
    localparam logic [PC_BITS-1:0] PC_FINISH = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FIRST,
        OP_INIT,
        OP_SCAN,
        OP_MOVE,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_GO,
        C_WANTED_EMPTY,
        C_UNVIS_EMPTY,
        C_SCAN_MORE
    } t_cond;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic [PC_BITS-1:0] target;
        logic               busy;
    } t_uword;

    typedef struct packed {
        logic wanted_empty;
        logic unvis_empty;
        logic scan_more;
    } t_status;

    function automatic t_uword uc_rom(input logic [PC_BITS-1:0] pc);
        t_uword w;
        w = '{op: OP_NONE, cond: C_NO_GO, target: PC_IDLE, busy: 1'b0};
        unique case (pc)
            PC_IDLE:   w = '{op: OP_NONE,   cond: C_NO_GO,        target: PC_IDLE, busy: 1'b0};
            PC_FIRST:  w = '{op: OP_FIRST,  cond: C_WANTED_EMPTY, target: PC_IDLE, busy: 1'b1};
            PC_TEST:   w = '{op: OP_INIT,   cond: C_UNVIS_EMPTY,  target: PC_FINISH, busy: 1'b1};
            PC_SCAN:   w = '{op: OP_SCAN,   cond: C_SCAN_MORE,    target: PC_SCAN, busy: 1'b1};
            PC_MOVE:   w = '{op: OP_MOVE,   cond: C_ALWAYS,       target: PC_TEST, busy: 1'b1};
            PC_FINISH: w = '{op: OP_FINISH, cond: C_ALWAYS,       target: PC_IDLE, busy: 1'b1};
            default:   w = '{op: OP_NONE,   cond: C_ALWAYS,       target: PC_IDLE, busy: 1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [DIST_BITS-1:0] sat_dist(input logic [IN_DIST_W-1:0] d);
        logic [DIST_BITS-1:0] r;
        if (64'(d) > DIST_MAX) begin
            r = DIST_BITS'(DIST_MAX);
        end else begin
            r = DIST_BITS'(d);
        end
        return r;
    endfunction

endpackage

### rtl/core/nnt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nnt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/nnt_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module nnt_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  nnt_pkg::t_status i_status,
    output nnt_pkg::t_uword  o_cw,
    output logic             o_busy
);
    import nnt_pkg::*;

    logic [PC_BITS-1:0] r_pc;
    logic [PC_BITS-1:0] n_pc;
    t_uword             cw;
    logic               take;

    always_comb begin
        cw = uc_rom(r_pc);
    end

    always_comb begin
        unique case (cw.cond)
            C_ALWAYS:       take = 1'b1;
            C_NO_GO:        take = ~i_go;
            C_WANTED_EMPTY: take = i_status.wanted_empty;
            C_UNVIS_EMPTY:  take = i_status.unvis_empty;
            C_SCAN_MORE:    take = i_status.scan_more;
            default:        take = 1'b1;
        endcase
        n_pc = take ? cw.target : r_pc + PC_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_cw   = cw;
    assign o_busy = cw.busy;

endmodule

### rtl/core/nnt_dpath.sv
// Datapath: distance memory, spot masks, nearest-spot scan and result register.
module nnt_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [nnt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [nnt_pkg::SPOT_W-1:0]    i_from_spot,
    input  logic [nnt_pkg::SPOT_W-1:0]    i_to_spot,
    input  logic [nnt_pkg::IN_DIST_W-1:0] i_distance,
    input  nnt_pkg::t_uword               i_cw,
    output nnt_pkg::t_status              o_status,
    output logic                          o_valid,
    output logic [nnt_pkg::SPOT_W-1:0]    o_spot,
    output logic                          o_last,
    output logic                          o_no_spots
);
    import nnt_pkg::*;

    logic [NODES-1:0]     r_wanted, n_wanted;
    logic [NODES-1:0]     r_unvis, n_unvis;
    logic [NODE_BITS-1:0] r_cur, n_cur;
    logic [NODE_BITS-1:0] r_start, n_start;
    logic [IDX_BITS-1:0]  r_idx, n_idx;
    logic                 r_rd_vld, n_rd_vld;
    logic [NODE_BITS-1:0] r_rd_idx, n_rd_idx;
    logic [NODE_BITS-1:0] r_best, n_best;
    logic [DIST_BITS-1:0] r_best_d, n_best_d;
    logic                 r_have, n_have;
    logic                 r_valid, n_valid;
    logic [SPOT_W-1:0]    r_spot, n_spot;
    logic                 r_last, n_last;
    logic                 r_no, n_no;

    logic                 from_ok, to_ok, we;
    logic [NODE_BITS-1:0] from_node, to_node, first;
    logic [ADDR_BITS-1:0] waddr, raddr;
    logic [DIST_BITS-1:0] rdata;

    assign from_ok   = 32'(i_from_spot) < NODES;
    assign to_ok     = 32'(i_to_spot) < NODES;
    assign from_node = NODE_BITS'(i_from_spot);
    assign to_node   = NODE_BITS'(i_to_spot);
    assign we        = i_accept && (i_req_type == REQ_WRITE) && from_ok && to_ok;
    assign waddr     = {from_node, to_node};
    assign raddr     = {r_cur, r_idx[NODE_BITS-1:0]};

    nnt_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (sat_dist(i_distance)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        first = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (r_wanted[i]) begin
                first = NODE_BITS'(i);
            end
        end
    end

    always_comb begin
        n_wanted = r_wanted;
        n_unvis  = r_unvis;
        n_cur    = r_cur;
        n_start  = r_start;
        n_idx    = r_idx;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;
        n_best   = r_best;
        n_best_d = r_best_d;
        n_have   = r_have;
        n_valid  = 1'b0;
        n_spot   = r_spot;
        n_last   = 1'b0;
        n_no     = 1'b0;

        if (i_accept && (i_req_type == REQ_MARK) && from_ok) begin
            n_wanted[from_node] = 1'b1;
        end

        // compare stage, in the cycle after the memory read
        if (r_rd_vld && r_unvis[r_rd_idx] && (!r_have || rdata < r_best_d)) begin
            n_best   = r_rd_idx;
            n_best_d = rdata;
            n_have   = 1'b1;
        end

        unique case (i_cw.op)
            OP_FIRST: begin
                n_valid = 1'b1;
                if (r_wanted == '0) begin
                    n_unvis = '0;
                    n_spot  = '0;
                    n_last  = 1'b1;
                    n_no    = 1'b1;
                end else begin
                    n_cur          = first;
                    n_start        = first;
                    n_unvis        = r_wanted;
                    n_unvis[first] = 1'b0;
                    n_spot         = SPOT_W'(first);
                end
            end
            OP_INIT: begin
                n_idx  = '0;
                n_have = 1'b0;
            end
            OP_SCAN: begin
                if (r_idx != IDX_BITS'(NODES)) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[NODE_BITS-1:0];
                    n_idx    = r_idx + IDX_BITS'(1);
                end
            end
            OP_MOVE: begin
                n_cur           = r_best;
                n_unvis[r_best] = 1'b0;
                n_valid         = 1'b1;
                n_spot          = SPOT_W'(r_best);
            end
            OP_FINISH: begin
                n_wanted = '0;
                n_unvis  = '0;
                n_valid  = 1'b1;
                n_spot   = SPOT_W'(r_start);
                n_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted <= '0;
            r_unvis  <= '0;
            r_start  <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
            r_last   <= 1'b0;
            r_no     <= 1'b0;
        end else begin
            r_wanted <= n_wanted;
            r_unvis  <= n_unvis;
            r_start  <= n_start;
            r_rd_vld <= n_rd_vld;
            r_valid  <= n_valid;
            r_last   <= n_last;
            r_no     <= n_no;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_best   <= n_best;
        r_best_d <= n_best_d;
        r_have   <= n_have;
        r_spot   <= n_spot;
    end

    assign o_status.wanted_empty = (r_wanted == '0);
    assign o_status.unvis_empty  = (r_unvis == '0);
    assign o_status.scan_more    = (r_idx != IDX_BITS'(NODES));

    assign o_valid    = r_valid;
    assign o_spot     = r_spot;
    assign o_last     = r_last;
    assign o_no_spots = r_no;

endmodule

### rtl/core/nearest_neighbour_tour.sv
// Top level of the nearest-neighbor tour block.
//
//  channel   | transaction when               | payload
//  ----------+--------------------------------+--------------------------------------
//  request   | i_start & !o_busy at clock edge| i_req_type i_from_spot i_to_spot i_distance
//  result    | o_valid, one cycle per result  | o_spot o_last o_no_spots
//
// Distance writes and wanted marks leave o_busy low.
// A start gives its start spot as the first result, then one result per further
// spot after a scan of its row (one memory read per spot of the row), and then a
// closing result that repeats the start spot. An empty start gives a single result.
// Reset is synchronous; it clears the wanted set and the sequencer.
// Results cannot be stalled; o_busy drops in the cycle of the last result.
module nearest_neighbour_tour (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [nnt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [nnt_pkg::SPOT_W-1:0]    i_from_spot,
    input  logic [nnt_pkg::SPOT_W-1:0]    i_to_spot,
    input  logic [nnt_pkg::IN_DIST_W-1:0] i_distance,
    output logic                          o_valid,
    output logic [nnt_pkg::SPOT_W-1:0]    o_spot,
    output logic                          o_last,
    output logic                          o_no_spots
);
    import nnt_pkg::*;

    logic    accept;
    logic    busy;
    t_uword  cw;
    t_status status;

    assign accept = i_start && !busy;

    nnt_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (accept && (i_req_type == REQ_START)),
        .i_status (status),
        .o_cw     (cw),
        .o_busy   (busy)
    );

    nnt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_from_spot (i_from_spot),
        .i_to_spot   (i_to_spot),
        .i_distance  (i_distance),
        .i_cw        (cw),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_spot      (o_spot),
        .o_last      (o_last),
        .o_no_spots  (o_no_spots)
    );

    assign o_busy = busy;

endmodule

### rtl/core/nnt_checker.sv
// Port-level checker for the nearest-neighbor tour block, bound to the top level.
module nnt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input logic                       o_busy,
    input logic [nnt_pkg::REQ_W-1:0]  i_req_type,
    input logic                       o_valid,
    input logic [nnt_pkg::SPOT_W-1:0] o_spot,
    input logic                       o_last,
    input logic                       o_no_spots
);
    import nnt_pkg::*;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_spots |-> o_last)
        else $error("error result not flagged last");

    a_err_spot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_spots |-> o_spot == '0)
        else $error("error result carries a spot");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_busy)
        else $error("busy held after last result");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_busy)
        else $error("tour result while idle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_req_type == REQ_START |=> o_busy)
        else $error("start transaction did not raise busy");

endmodule

bind nearest_neighbour_tour nnt_checker u_nnt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .i_req_type (i_req_type),
    .o_valid    (o_valid),
    .o_spot     (o_spot),
    .o_last     (o_last),
    .o_no_spots (o_no_spots)
);
